/* rtl/core/raycast_column_renderer_top_macros.svh */
// assertion macros for the ray cast column renderer
`ifndef RAYCAST_COLUMN_RENDERER_TOP_MACROS_SVH
`define RAYCAST_COLUMN_RENDERER_TOP_MACROS_SVH

// same-cycle implication
`define RCR_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RCR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/rcr_pkg.sv */
// shared constants and types of the ray cast column renderer
package rcr_pkg;

   localparam int SCREEN_ROWS_DEF    = 40;
   localparam int SCREEN_COLUMNS_DEF = 120;
   localparam int MAP_SIDE_DEF       = 16;

   // row counter must hold the row count itself (at most 64)
   localparam int ROW_CNT_W = 7;

   // divider geometry
   localparam int DIV_W = 24;
   localparam int DVS_W = 18;

   // register indexes
   localparam logic [2:0] REG_WALL0 = 3'd0;
   localparam logic [2:0] REG_WALL1 = 3'd1;
   localparam logic [2:0] REG_WALL2 = 3'd2;
   localparam logic [2:0] REG_WALL3 = 3'd3;
   localparam logic [2:0] REG_RANGE = 3'd4;
   localparam logic [2:0] REG_FOV   = 3'd5;

   localparam logic [16:0] STEP_Q12  = 17'd410;
   localparam logic [16:0] RANGE_MAX = 17'd65536;
   localparam logic [15:0] FOV_RESET = 16'd8192;

   // quarter sine polynomial
   localparam logic [14:0] SIN_K1 = 15'd25736;
   localparam logic [13:0] SIN_K2 = 14'd10512;
   localparam logic [10:0] SIN_K3 = 11'd1160;

   // corner edge threshold
   localparam logic [13:0] EDGE_K = 14'd10000;

   typedef enum logic [3:0] {
      CELL_BLANK  = 4'd0,
      CELL_FULL   = 4'd1,
      CELL_DARK   = 4'd2,
      CELL_MEDIUM = 4'd3,
      CELL_LIGHT  = 4'd4,
      CELL_HASH   = 4'd5,
      CELL_CROSS  = 4'd6,
      CELL_DASH   = 4'd7,
      CELL_DOT    = 4'd8
   } cell_type;

   typedef enum logic [9:0] {
      ST_IDLE   = 10'b0000000001,
      ST_FOVMUL = 10'b0000000010,
      ST_DIV    = 10'b0000000100,
      ST_SINE   = 10'b0000001000,
      ST_MARCH  = 10'b0000010000,
      ST_CORNER = 10'b0000100000,
      ST_SELECT = 10'b0001000000,
      ST_SAT    = 10'b0010000000,
      ST_NUM    = 10'b0100000000,
      ST_ROWS   = 10'b1000000000
   } state_type;

endpackage

/* rtl/core/raycast_column_renderer_top.sv */
// ray cast column renderer: fixed-step march and row shading on one shared multiplier
//
// One request casts one ray and returns SCREEN_ROWS row cells, top row first. All
// arithmetic runs through a single 25x25 multiplier and a radix-2 divider under a
// sequencer, and the block takes no request until the last row has been taken. Each
// column passes through the column angle (multiply, then reciprocal multiply), eight
// sine multiplies, N march steps (one multiply for x, one for y, one tile check each;
// N is at most 160 at full range), the saturate and numerator states, the 24-step row
// division, the row outputs (held by output stalls) and a closing step; a ray that
// stops at a wall adds 32 corner multiplies and a corner select before saturation.
`include "raycast_column_renderer_top_macros.svh"

module raycast_column_renderer_top #(
   parameter int SCREEN_ROWS    = rcr_pkg::SCREEN_ROWS_DEF,
   parameter int SCREEN_COLUMNS = rcr_pkg::SCREEN_COLUMNS_DEF,
   parameter int MAP_SIDE       = rcr_pkg::MAP_SIDE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // pos_x, pos_y, view_angle, column
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // row, cell_code, wall_distance
   output logic        rsp_tlast,   // last_row
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [63:0] csr_wdata
);
   import rcr_pkg::*;

   localparam logic [11:0] RW  = 12'(SCREEN_ROWS);
   localparam logic [11:0] RW3 = 12'(3 * SCREEN_ROWS);
   localparam logic [11:0] RW9 = 12'(9 * SCREEN_ROWS);

   // column * fov stays below 2^23, so this reciprocal gives the exact quotient
   localparam int          COL_SHIFT = 23 + $clog2(SCREEN_COLUMNS);
   localparam logic [24:0] COL_RECIP =
      25'(((64'd1 << COL_SHIFT) + 64'(SCREEN_COLUMNS - 1)) / 64'(SCREEN_COLUMNS));

   // configuration
   logic [63:0] wall0_ff, wall1_ff, wall2_ff, wall3_ff;
   logic [16:0] range_ff;
   logic [15:0] fov_ff;
   logic [16:0] rng;

   always_ff @(posedge clock) begin
      if (reset) begin
         wall0_ff <= '0;
         wall1_ff <= '0;
         wall2_ff <= '0;
         wall3_ff <= '0;
         range_ff <= RANGE_MAX;
         fov_ff   <= FOV_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            REG_WALL0: wall0_ff <= csr_wdata;
            REG_WALL1: wall1_ff <= csr_wdata;
            REG_WALL2: wall2_ff <= csr_wdata;
            REG_WALL3: wall3_ff <= csr_wdata;
            REG_RANGE: range_ff <= csr_wdata[16:0];
            REG_FOV:   fov_ff   <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // effective range
   always_comb begin
      if (range_ff == 17'd0) rng = 17'd1;
      else if (range_ff > RANGE_MAX) rng = RANGE_MAX;
      else rng = range_ff;
   end

   logic [255:0] wall_bits;
   assign wall_bits = {wall3_ff, wall2_ff, wall1_ff, wall0_ff};

   // sequencer and datapath registers
   state_type          state_ff, state_in;
   logic [4:0]         sub_ff, sub_in;
   logic               pass_ff, pass_in;
   logic [15:0]        px_ff, px_in, py_ff, py_in, view_ff, view_in;
   logic [6:0]         col_ff, col_in;
   logic [DIV_W-1:0]   quo_ff, quo_in;
   logic [DVS_W-1:0]   rem_ff, rem_in, dvs_ff, dvs_in;
   logic               neg_ff, neg_in;
   logic [15:0]        ang_ff, ang_in;
   logic [14:0]        u2_ff, u2_in, t_ff, t_in;
   logic signed [16:0] ux_ff, ux_in, uy_ff, uy_in;
   logic [16:0]        d_ff, d_in;
   logic signed [19:0] qx_ff, qx_in, qy_ff, qy_in;
   logic [3:0]         tx_ff, tx_in, ty_ff, ty_in;
   logic signed [35:0] acc_ff, acc_in;
   logic               dotpos_ff, dotpos_in, big_ff, big_in;
   logic [11:0]        mc_ff, mc_in;
   logic [23:0]        msq_ff, msq_in;
   logic [33:0]        vv_ff [4];
   logic [33:0]        vv_in [4];
   logic [3:0]         edge_ff, edge_in;
   logic               edge_hit_ff, edge_hit_in;
   cell_type           shade_ff, shade_in;
   logic signed [24:0] ceil_ff, ceil_in, floor_ff, floor_in;
   logic [ROW_CNT_W-1:0] y_ff, y_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [5:0]         rsp_row_ff, rsp_row_in;
   logic [3:0]         rsp_code_ff, rsp_code_in;
   logic [16:0]        rsp_dist_ff, rsp_dist_in;
   logic               rsp_last_ff, rsp_last_in;

   // shared multiplier
   logic signed [24:0] mul_a, mul_b;
   logic signed [49:0] prod;
   assign prod = mul_a * mul_b;

   // sine phase of the current pass
   logic [15:0] sa;
   logic [14:0] su;
   assign sa = pass_ff ? (ang_ff + 16'd16384) : ang_ff;
   assign su = sa[14] ? (15'd16384 - {1'b0, sa[13:0]}) : {1'b0, sa[13:0]};

   // corner vector of the current corner
   logic [4:0]         cx, cy;
   logic signed [17:0] vx, vy;
   assign cx = {1'b0, tx_ff} + {4'b0, sub_ff[4]};
   assign cy = {1'b0, ty_ff} + {4'b0, sub_ff[3]};
   assign vx = $signed({1'b0, cx, 12'b0}) - $signed({2'b0, px_ff});
   assign vy = $signed({1'b0, cy, 12'b0}) - $signed({2'b0, py_ff});

   logic signed [24:0] dm8;
   assign dm8 = $signed({8'b0, d_ff}) - 25'sd8192;

   // operand selection
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_FOVMUL: begin
            if (sub_ff[0]) begin
               mul_a = {1'b0, quo_ff};
               mul_b = COL_RECIP;
            end else begin
               mul_a = {18'b0, col_ff};
               mul_b = {9'b0, fov_ff};
            end
         end
         ST_SINE: begin
            case (sub_ff[1:0])
               2'd0: begin
                  mul_a = {10'b0, su};
                  mul_b = {10'b0, su};
               end
               2'd1: begin
                  mul_a = {14'b0, SIN_K3};
                  mul_b = {10'b0, u2_ff};
               end
               2'd2: begin
                  mul_a = {10'b0, u2_ff};
                  mul_b = {11'b0, SIN_K2 - t_ff[13:0]};
               end
               default: begin
                  mul_a = {10'b0, su};
                  mul_b = {10'b0, SIN_K1 - t_ff};
               end
            endcase
         end
         ST_MARCH: begin
            mul_a = sub_ff[0] ? {{8{uy_ff[16]}}, uy_ff} : {{8{ux_ff[16]}}, ux_ff};
            mul_b = {8'b0, d_ff};
         end
         ST_CORNER: begin
            case (sub_ff[2:0])
               3'd0: begin
                  mul_a = {{8{ux_ff[16]}}, ux_ff};
                  mul_b = {{7{vx[17]}}, vx};
               end
               3'd1: begin
                  mul_a = {{8{uy_ff[16]}}, uy_ff};
                  mul_b = {{7{vy[17]}}, vy};
               end
               3'd2: begin
                  mul_a = {{8{ux_ff[16]}}, ux_ff};
                  mul_b = {{7{vy[17]}}, vy};
               end
               3'd3: begin
                  mul_a = {{8{uy_ff[16]}}, uy_ff};
                  mul_b = {{7{vx[17]}}, vx};
               end
               3'd4: begin
                  mul_a = {{7{vx[17]}}, vx};
                  mul_b = {{7{vx[17]}}, vx};
               end
               3'd5: begin
                  mul_a = {{7{vy[17]}}, vy};
                  mul_b = {{7{vy[17]}}, vy};
               end
               3'd6: begin
                  mul_a = {13'b0, mc_ff};
                  mul_b = {13'b0, mc_ff};
               end
               default: begin
                  mul_a = {11'b0, EDGE_K};
                  mul_b = {1'b0, msq_ff};
               end
            endcase
         end
         ST_NUM: begin
            mul_a = 25'(SCREEN_ROWS);
            mul_b = dm8;
         end
         default: ;
      endcase
   end

   // nearest two corners
   logic [1:0] sel_a, sel_b;
   always_comb begin
      sel_a = 2'd0;
      for (int i = 1; i < 4; i++) begin
         if (vv_ff[i] < vv_ff[sel_a]) sel_a = 2'(i);
      end
      sel_b = (sel_a == 2'd0) ? 2'd1 : 2'd0;
      for (int i = 0; i < 4; i++) begin
         if (2'(i) != sel_a && vv_ff[i] < vv_ff[sel_b]) sel_b = 2'(i);
      end
   end

   // divider step
   logic [DVS_W:0] trial;
   logic           div_ge;
   logic [DVS_W:0] trial_sub;
   assign trial     = {rem_ff, quo_ff[DIV_W-1]};
   assign div_ge    = trial >= {1'b0, dvs_ff};
   assign trial_sub = trial - {1'b0, dvs_ff};

   // row cell code
   logic signed [24:0] ysg;
   logic [11:0]        kk;
   cell_type           code;
   assign ysg = $signed({18'b0, y_ff});
   assign kk  = RW - {5'b0, y_ff};
   always_comb begin
      if (ysg < ceil_ff) code = CELL_BLANK;
      else if (ysg > ceil_ff && ysg <= floor_ff) code = shade_ff;
      else if ({kk[8:0], 3'b0} < RW) code = CELL_HASH;
      else if ({kk[9:0], 2'b0} < RW) code = CELL_CROSS;
      else if ({kk[8:0], 3'b0} < RW3) code = CELL_DASH;
      else if (12'(kk * 12'd20) < RW9) code = CELL_DOT;
      else code = CELL_BLANK;
   end

   logic out_free;
   assign out_free = !rsp_valid_ff || rsp_tready;

   // sequencer
   logic signed [35:0] dot, cr, crmag;
   logic signed [24:0] nm, nmag;
   logic [15:0]        sq;
   logic signed [16:0] sv;
   logic               out_map;
   logic [18:0]        d4, d3;
   logic [17:0]        d2;

   always_comb begin
      state_in     = state_ff;
      sub_in       = sub_ff;
      pass_in      = pass_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      view_in      = view_ff;
      col_in       = col_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      dvs_in       = dvs_ff;
      neg_in       = neg_ff;
      ang_in       = ang_ff;
      u2_in        = u2_ff;
      t_in         = t_ff;
      ux_in        = ux_ff;
      uy_in        = uy_ff;
      d_in         = d_ff;
      qx_in        = qx_ff;
      qy_in        = qy_ff;
      tx_in        = tx_ff;
      ty_in        = ty_ff;
      acc_in       = acc_ff;
      dotpos_in    = dotpos_ff;
      big_in       = big_ff;
      mc_in        = mc_ff;
      msq_in       = msq_ff;
      vv_in        = vv_ff;
      edge_in      = edge_ff;
      edge_hit_in  = edge_hit_ff;
      shade_in     = shade_ff;
      ceil_in      = ceil_ff;
      floor_in     = floor_ff;
      y_in         = y_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_code_in  = rsp_code_ff;
      rsp_dist_in  = rsp_dist_ff;
      rsp_last_in  = rsp_last_ff;

      dot     = acc_ff + prod[35:0];
      cr      = acc_ff - prod[35:0];
      crmag   = cr[35] ? -cr : cr;
      nm      = prod[24:0];
      nmag    = nm[24] ? -nm : nm;
      sq      = prod[29:14];
      sv      = $signed({1'b0, sq});
      out_map = qx_ff[19] || qy_ff[19] ||
                (qx_ff[18:12] >= 7'(MAP_SIDE)) || (qy_ff[18:12] >= 7'(MAP_SIDE));
      d4      = {d_ff, 2'b0};
      d3      = {1'b0, d_ff, 1'b0} + {2'b0, d_ff};
      d2      = {d_ff, 1'b0};

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               px_in       = req_tdata[15:0];
               py_in       = req_tdata[31:16];
               view_in     = req_tdata[47:32];
               col_in      = req_tdata[54:48];
               edge_hit_in = 1'b0;
               sub_in      = '0;
               state_in    = ST_FOVMUL;
            end
         end
         // column offset: product first, then its quotient by the column count
         ST_FOVMUL: begin
            if (!sub_ff[0]) begin
               quo_in = prod[DIV_W-1:0];
               sub_in = 5'd1;
            end else begin
               ang_in   = view_ff - {1'b0, fov_ff[15:1]} + prod[COL_SHIFT +: 16];
               pass_in  = 1'b0;
               sub_in   = '0;
               state_in = ST_SINE;
            end
         end
         ST_DIV: begin
            rem_in = div_ge ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], div_ge};
            sub_in = sub_ff - 5'd1;
            if (sub_ff == 5'd0) begin
               ceil_in  = neg_ff ? -$signed({1'b0, quo_in}) : $signed({1'b0, quo_in});
               floor_in = $signed(25'(SCREEN_ROWS)) - ceil_in;
               y_in     = '0;
               state_in = ST_ROWS;
            end
         end
         ST_SINE: begin
            sub_in = sub_ff + 5'd1;
            case (sub_ff[1:0])
               2'd0: u2_in = prod[28:14];
               2'd1: t_in  = prod[28:14];
               2'd2: t_in  = prod[28:14];
               default: begin
                  sub_in = '0;
                  if (pass_ff) begin
                     uy_in    = sa[15] ? -sv : sv;
                     d_in     = STEP_Q12;
                     state_in = ST_MARCH;
                  end else begin
                     ux_in   = sa[15] ? -sv : sv;
                     pass_in = 1'b1;
                  end
               end
            endcase
         end
         ST_MARCH: begin
            sub_in = sub_ff + 5'd1;
            if (sub_ff == 5'd0) begin
               qx_in = $signed({4'b0, px_ff}) + {{2{prod[31]}}, prod[31:14]};
            end else if (sub_ff == 5'd1) begin
               qy_in = $signed({4'b0, py_ff}) + {{2{prod[31]}}, prod[31:14]};
            end else begin
               sub_in = '0;
               if (out_map) begin
                  d_in     = rng;
                  state_in = ST_SAT;
               end else if (wall_bits[{qy_ff[15:12], qx_ff[15:12]}]) begin
                  tx_in    = qx_ff[15:12];
                  ty_in    = qy_ff[15:12];
                  state_in = ST_CORNER;
               end else if (d_ff < rng) begin
                  d_in = d_ff + STEP_Q12;
               end else begin
                  state_in = ST_SAT;
               end
            end
         end
         ST_CORNER: begin
            sub_in = sub_ff + 5'd1;
            case (sub_ff[2:0])
               3'd0, 3'd2, 3'd4: acc_in = prod[35:0];
               3'd1: dotpos_in = !dot[35] && (dot != 36'sd0);
               3'd3: begin
                  big_in = |crmag[35:24];
                  mc_in  = crmag[23:12];
               end
               3'd5: vv_in[sub_ff[4:3]] = acc_ff[33:0] + prod[33:0];
               3'd6: msq_in = prod[23:0];
               default: begin
                  edge_in[sub_ff[4:3]] = dotpos_ff && (vv_ff[sub_ff[4:3]] != 34'd0) &&
                                         !big_ff &&
                                         (prod[37:0] < {vv_ff[sub_ff[4:3]], 4'b0});
                  if (sub_ff == 5'd31) state_in = ST_SELECT;
               end
            endcase
         end
         ST_SELECT: begin
            edge_hit_in = edge_ff[sel_a] || edge_ff[sel_b];
            state_in    = ST_SAT;
         end
         ST_SAT: begin
            if (d_ff > rng) d_in = rng;
            state_in = ST_NUM;
         end
         ST_NUM: begin
            quo_in      = nmag[DIV_W-1:0];
            rem_in      = '0;
            dvs_in      = {d_ff, 1'b0};
            neg_in      = nm[24];
            sub_in      = 5'(DIV_W - 1);
            if (edge_hit_ff) shade_in = CELL_BLANK;
            else if (d4 <= {2'b0, rng}) shade_in = CELL_FULL;
            else if (d3 < {2'b0, rng}) shade_in = CELL_DARK;
            else if (d2 < {1'b0, rng}) shade_in = CELL_MEDIUM;
            else if (d_ff < rng) shade_in = CELL_LIGHT;
            else shade_in = CELL_BLANK;
            state_in = ST_DIV;
         end
         ST_ROWS: begin
            if (out_free) begin
               if (y_ff < ROW_CNT_W'(SCREEN_ROWS)) begin
                  rsp_valid_in = 1'b1;
                  rsp_row_in   = y_ff[5:0];
                  rsp_code_in  = code;
                  rsp_dist_in  = d_ff;
                  rsp_last_in  = (y_ff == ROW_CNT_W'(SCREEN_ROWS - 1));
                  y_in         = y_ff + 1'b1;
               end else begin
                  rsp_valid_in = 1'b0;
                  state_in     = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sub_ff       <= '0;
         pass_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         y_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         sub_ff       <= sub_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
         y_ff         <= y_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      px_ff       <= px_in;
      py_ff       <= py_in;
      view_ff     <= view_in;
      col_ff      <= col_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      dvs_ff      <= dvs_in;
      neg_ff      <= neg_in;
      ang_ff      <= ang_in;
      u2_ff       <= u2_in;
      t_ff        <= t_in;
      ux_ff       <= ux_in;
      uy_ff       <= uy_in;
      d_ff        <= d_in;
      qx_ff       <= qx_in;
      qy_ff       <= qy_in;
      tx_ff       <= tx_in;
      ty_ff       <= ty_in;
      acc_ff      <= acc_in;
      dotpos_ff   <= dotpos_in;
      big_ff      <= big_in;
      mc_ff       <= mc_in;
      msq_ff      <= msq_in;
      vv_ff       <= vv_in;
      edge_ff     <= edge_in;
      edge_hit_ff <= edge_hit_in;
      shade_ff    <= shade_in;
      ceil_ff     <= ceil_in;
      floor_ff    <= floor_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_code_ff <= rsp_code_in;
      rsp_dist_ff <= rsp_dist_in;
      rsp_last_ff <= rsp_last_in;
   end

   // ports
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_dist_ff, rsp_code_ff, rsp_row_ff};
   assign rsp_tlast  = rsp_last_ff;

   // checks
   `RCR_ASSERT_NOW(a_idle_no_rsp, clock, reset, req_tready, !rsp_tvalid, "result pending while idle")
   `RCR_ASSERT_NEXT(a_last_to_idle, clock, reset, rsp_tvalid && rsp_tready && rsp_tlast, req_tready, "not idle after last row")
   `RCR_ASSERT_NOW(a_dist_in_range, clock, reset, rsp_tvalid, rsp_tdata[26:10] <= rng, "distance above range")
   `RCR_ASSERT_NOW(a_div_nonzero, clock, reset, state_ff == ST_DIV, dvs_ff != '0, "divide by zero")

endmodule

/* tb/raycast_column_checker.sv */
// transfer monitor, column predictor and result checker for the ray cast column renderer
`timescale 1ns / 1ps

module raycast_column_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [55:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [63:0] csr_wdata,
   output int          pending,
   output int          fail_count
);
   import rcr_pkg::*;

   localparam longint ROWS = SCREEN_ROWS_DEF;
   localparam longint COLS = SCREEN_COLUMNS_DEF;
   localparam longint SIDE = MAP_SIDE_DEF;

   typedef struct packed {
      logic [5:0]  row;
      logic [3:0]  cell_code;
      logic [16:0] wall_dist;
      logic        last;
   } row_cell_type;

   row_cell_type cell_queue[$];
   logic [63:0]  wall_word[4];
   logic [16:0]  range_reg;
   logic [15:0]  fov_reg;

   assign pending = cell_queue.size();

   function automatic longint quarter_sine(longint u);
      longint u2, c2, t2;
      u2 = (u * u) >>> 14;
      c2 = (longint'(SIN_K3) * u2) >>> 14;
      t2 = (u2 * (longint'(SIN_K2) - c2)) >>> 14;
      return (u * (longint'(SIN_K1) - t2)) >>> 14;
   endfunction

   function automatic longint sine_q14(longint a);
      longint q, f, s;
      q = (a >> 14) & 3;
      f = a & 16'h3FFF;
      if (q[0]) f = 16384 - f;
      s = quarter_sine(f);
      return q[1] ? -s : s;
   endfunction

   function automatic bit is_wall(longint tx, longint ty);
      return wall_word[ty >> 2][((ty & 3) << 4) + tx];
   endfunction

   // ray grazes one of the two nearest corners of the hit tile
   function automatic bit grazes_corner(longint tx, longint ty, longint px, longint py,
                                        longint ux, longint uy);
      longint vv[4];
      bit     hit_edge[4];
      longint vx, vy, dt, cr, mc;
      int     a, b;
      a = 0;
      b = -1;
      for (int i = 0; i < 4; i++) begin
         vx = (tx + (i >> 1)) * 4096 - px;
         vy = (ty + (i & 1)) * 4096 - py;
         dt = ux * vx + uy * vy;
         cr = ux * vy - uy * vx;
         mc = (cr < 0 ? -cr : cr) >>> 12;
         vv[i] = vx * vx + vy * vy;
         hit_edge[i] = dt > 0 && vv[i] > 0 && longint'(EDGE_K) * mc * mc < (vv[i] << 4);
      end
      for (int i = 1; i < 4; i++) if (vv[i] < vv[a]) a = i;
      for (int i = 0; i < 4; i++) begin
         if (i == a) continue;
         if (b < 0 || vv[i] < vv[b]) b = i;
      end
      return hit_edge[a] || hit_edge[b];
   endfunction

   // march one ray and queue the row cells of its column
   task automatic predict_column(logic [55:0] item);
      longint px, py, view, col, rng, fov, ang, ux, uy, d, qx, qy, tx, ty;
      longint ceil_row, floor_row, k;
      bit hit, edge_hit;
      logic [3:0] shade, code;
      row_cell_type c;
      px = item[15:0];
      py = item[31:16];
      view = item[47:32];
      col = item[54:48];
      rng = range_reg;
      fov = fov_reg;
      if (rng == 0) rng = 1;
      if (rng > 65536) rng = 65536;
      ang = (view - (fov >> 1) + (col * fov) / COLS) & 16'hFFFF;
      ux = sine_q14(ang);
      uy = sine_q14((ang + 16384) & 16'hFFFF);
      d = 0;
      hit = 0;
      edge_hit = 0;
      while (!hit && d < rng) begin
         d += STEP_Q12;
         qx = px + ((ux * d) >>> 14);
         qy = py + ((uy * d) >>> 14);
         tx = qx >= 0 ? qx >>> 12 : -1;
         ty = qy >= 0 ? qy >>> 12 : -1;
         if (tx < 0 || ty < 0 || tx >= SIDE || ty >= SIDE) begin
            hit = 1;
            d = rng;
         end else if (is_wall(tx, ty)) begin
            hit = 1;
            edge_hit = grazes_corner(tx, ty, px, py, ux, uy);
         end
      end
      if (d > rng) d = rng;
      ceil_row = (ROWS * d - 8192 * ROWS) / (2 * d);
      floor_row = ROWS - ceil_row;
      if (4 * d <= rng) shade = CELL_FULL;
      else if (3 * d < rng) shade = CELL_DARK;
      else if (2 * d < rng) shade = CELL_MEDIUM;
      else if (d < rng) shade = CELL_LIGHT;
      else shade = CELL_BLANK;
      if (edge_hit) shade = CELL_BLANK;
      for (longint y = 0; y < ROWS; y++) begin
         k = ROWS - y;
         if (y < ceil_row) code = CELL_BLANK;
         else if (y > ceil_row && y <= floor_row) code = shade;
         else if (8 * k < ROWS) code = CELL_HASH;
         else if (4 * k < ROWS) code = CELL_CROSS;
         else if (8 * k < 3 * ROWS) code = CELL_DASH;
         else if (20 * k < 9 * ROWS) code = CELL_DOT;
         else code = CELL_BLANK;
         c.row = y[5:0];
         c.cell_code = code;
         c.wall_dist = d[16:0];
         c.last = (y == ROWS - 1);
         cell_queue = {cell_queue, c};
      end
   endtask

   function automatic void report(string msg);
      fail_count++;
      if (fail_count <= 10) $display("mismatch: %s", msg);
   endfunction

   // register mirror, request capture and result compare
   always @(posedge clock) begin
      row_cell_type e;
      if (reset) begin
         foreach (wall_word[i]) wall_word[i] = '0;
         range_reg = RANGE_MAX;
         fov_reg = FOV_RESET;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               REG_WALL0, REG_WALL1, REG_WALL2, REG_WALL3: wall_word[csr_addr] = csr_wdata;
               REG_RANGE: range_reg = csr_wdata[16:0];
               REG_FOV:   fov_reg = csr_wdata[15:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (cell_queue.size() == 0) begin
               report($sformatf("unexpected transfer data %h last %b", rsp_tdata, rsp_tlast));
            end else begin
               e = cell_queue.pop_front();
               if (rsp_tdata[5:0] !== e.row)
                  report($sformatf("row exp %0d got %0d", e.row, rsp_tdata[5:0]));
               if (rsp_tdata[9:6] !== e.cell_code)
                  report($sformatf("row %0d cell exp %0d got %0d", e.row, e.cell_code,
                                   rsp_tdata[9:6]));
               if (rsp_tdata[26:10] !== e.wall_dist)
                  report($sformatf("row %0d distance exp %0d got %0d", e.row, e.wall_dist,
                                   rsp_tdata[26:10]));
               if (rsp_tdata[31:27] !== 5'd0)
                  report($sformatf("row %0d pad bits %b", e.row, rsp_tdata[31:27]));
               if (rsp_tlast !== e.last)
                  report($sformatf("row %0d last exp %b got %b", e.row, e.last, rsp_tlast));
            end
         end
         if (req_tvalid && req_tready) predict_column(req_tdata);
      end
   end

   initial fail_count = 0;

endmodule

/* tb/tb_top.sv */
// stimulus, clock, reset and verdict for the ray cast column renderer
`timescale 1ns / 1ps

module tb_top;
   import rcr_pkg::*;

   localparam int CYCLE_LIMIT = 8000000;
   localparam int DRAIN_WAIT  = 800;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [55:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we;
   logic [2:0]  csr_addr;
   logic [63:0] csr_wdata;
   int          pending;
   int          fail_count;
   int          cycle_count;
   bit          no_idle;

   raycast_column_renderer_top i_dut (.*);

   raycast_column_checker i_checker (.*);

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // run limit
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("raycast_column_renderer_top verification failed");
         $finish;
      end
   end

   // mostly short gaps, a few long ones
   function automatic int gap_len();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // result side back pressure
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else if (no_idle) rsp_tready <= 1'b1;
      else rsp_tready <= (gap_len() == 0);
   end

   // one write cycle, then the write enable drops before the task returns
   task automatic write_reg(logic [2:0] idx, logic [63:0] val);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // stop sending, let every pending row drain, then give the block time to settle
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // valid stays up after the transfer until a gap or a drain drops it
   task automatic send_column(logic [15:0] px, logic [15:0] py, logic [15:0] ang,
                              logic [6:0] col);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {1'b0, col, ang, py, px};
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [63:0] map_word(int density);
      case (density)
         0: return '0;
         1: return rand64() & rand64() & rand64();
         2: return rand64();
         default: return ~64'd0;
      endcase
   endfunction

   initial begin
      logic [16:0] rng;
      logic [15:0] fov;
      int dens;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_addr = '0;
      csr_wdata = '0;
      no_idle = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings, empty map, edges of the fields
      send_column(16'h0000, 16'h0000, 16'h0000, 7'd0);
      send_column(16'hFFFF, 16'hFFFF, 16'hFFFF, 7'd119);
      send_column(16'h8000, 16'h8000, 16'h4000, 7'd60);
      send_column(16'h8000, 16'h8000, 16'h8000, 7'd127);
      send_column(16'h8000, 16'h8000, 16'hC000, 7'd120);
      drain();

      // directed: walls around the center, short and clamped ranges
      write_reg(REG_WALL0, 64'hFFFF_8001_8001_8001);
      write_reg(REG_WALL1, 64'h8001_8001_8001_8001);
      write_reg(REG_WALL2, 64'h8001_8001_8001_8001);
      write_reg(REG_WALL3, 64'hFFFF_8001_8001_8001);
      write_reg(REG_RANGE, 64'd65536);
      write_reg(REG_FOV, 64'd32768);
      write_reg(3'd6, rand64());
      write_reg(3'd7, rand64());
      for (int i = 0; i < 8; i++)
         send_column(16'h8000, 16'h8000, 16'(i * 8192), 7'(i * 17));
      // corner grazing: aim at a corner of the border
      send_column(16'h2000, 16'h2000, 16'hA000, 7'd60);
      send_column(16'h1800, 16'h1800, 16'hA000, 7'd60);
      drain();
      write_reg(REG_RANGE, 64'd0);
      write_reg(REG_FOV, 64'd1);
      send_column(16'h8000, 16'h8000, 16'h0000, 7'd0);
      drain();
      write_reg(REG_RANGE, 64'h1FFFF);
      write_reg(REG_FOV, 64'hFFFF);
      send_column(16'h8000, 16'h8000, 16'h1234, 7'd127);
      drain();
      write_reg(REG_RANGE, 64'd1);
      write_reg(REG_FOV, 64'd0);
      send_column(16'h4000, 16'hC000, 16'h7000, 7'd5);
      drain();

      // random phases, each with its own map and settings
      for (int ph = 0; ph < 20; ph++) begin
         no_idle = (ph % 5 == 4);
         dens = $urandom_range(0, 9);
         dens = dens < 1 ? 0 : dens < 6 ? 1 : dens < 9 ? 2 : 3;
         for (int w = 0; w < 4; w++) write_reg(3'(w), map_word(dens));
         case ($urandom_range(0, 5))
            0: rng = 17'd65536;
            1: rng = 17'd1;
            2: rng = 17'($urandom_range(0, 131071));
            default: rng = 17'($urandom_range(2000, 65536));
         endcase
         case ($urandom_range(0, 5))
            0: fov = 16'd32768;
            1: fov = 16'd1;
            2: fov = 16'($urandom());
            default: fov = 16'($urandom_range(1, 32768));
         endcase
         write_reg(REG_RANGE, 64'(rng));
         write_reg(REG_FOV, 64'(fov));
         for (int n = 0; n < 21; n++)
            send_column(16'($urandom()), 16'($urandom()), 16'($urandom()),
                        ($urandom_range(0, 9) == 0) ? 7'($urandom()) : 7'($urandom_range(0, 119)));
         drain();
      end

      if (fail_count == 0 && pending == 0) begin
         $display("raycast_column_renderer_top verification clean");
      end else begin
         $display("raycast_column_renderer_top verification failed");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/rcr_pkg.sv
rtl/core/raycast_column_renderer_top.sv
tb/raycast_column_checker.sv
tb/tb_top.sv
